/* rtl/ldbe_pkg.sv */
// Shared types, constants and codes for the LEDBAT delay estimator.
package ldbe_pkg;

  localparam int unsigned DEF_NOISE_DEPTH = 16;
  localparam int unsigned DEF_BASE_DEPTH  = 16;
  localparam int unsigned DEF_ROLLOVER_MS = 60000;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [4:0]  GAIN_CAP = 5'd16;

  localparam logic [15:0] RST_TARGET_MS = 16'd60;
  localparam logic [4:0]  RST_BASE_LEN  = 5'd10;
  localparam logic [4:0]  RST_NOISE_LEN = 5'd4;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEN = 2'd2;

  typedef struct packed {
    logic [31:0] rtt_ms;
    logic        rtt_positive;
    logic        timestamp_ok;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0] current_delay;
    logic [31:0] base_ms;
    logic [31:0] queue_ms;
    logic        delay_valid;
    logic [4:0]  gain_divisor;
  } out_item_t;

  // Per-cell controls handed from the window to each of its cells.
  typedef struct packed {
    logic shift;
    logic merge;
    logic active;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_GAIN,
    ST_WAIT,
    ST_OUT
  } state_e;

endpackage

/* rtl/ldbe_cell.sv */
// One cell of a delay window: a stored sample and a stage of the running minimum.
module ldbe_cell (
  input  logic                clk_i,
  input  ldbe_pkg::cell_ctrl_t ctrl_i,
  input  logic [31:0]         d_i,
  input  logic [31:0]         min_i,
  output logic [31:0]         val_o,
  output logic [31:0]         min_o
);
  import ldbe_pkg::*;

  logic [31:0] val_q, val_d;
  logic [31:0] min_q, min_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = d_i;
    end else if (ctrl_i.merge && (d_i < val_q)) begin
      val_d = d_i;
    end
    // An occupied cell folds its sample into the minimum passing through.
    min_d = (ctrl_i.active && (val_q < min_i)) ? val_q : min_i;
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    min_q <= min_d;
  end

  assign val_o = val_q;
  assign min_o = min_q;

endmodule

/* rtl/ldbe_window.sv */
// A row of cells holding the newest samples, newest at the head, with its fill count.
module ldbe_window #(
  parameter int unsigned DEPTH = ldbe_pkg::DEF_NOISE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        merge_i,
  input  logic [31:0] data_i,
  input  logic [4:0]  len_i,
  output logic [31:0] min_o,
  output logic        empty_o
);
  import ldbe_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] grown;
  logic [31:0]      vals [DEPTH];
  logic [31:0]      mins [DEPTH];

  always_comb begin
    if (len_i == '0) begin
      lim = CNT_W'(1);
    end else if (32'(len_i) > 32'(DEPTH)) begin
      lim = CNT_W'(DEPTH);
    end else begin
      lim = CNT_W'(len_i);
    end
    grown   = (count_q == CNT_W'(DEPTH)) ? count_q : count_q + CNT_W'(1);
    count_d = count_q;
    if (push_i) begin
      // Trimming the oldest entries only means shortening the count.
      count_d = (grown > lim) ? lim : grown;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t  ctrl;
    logic [31:0] d_in;
    logic [31:0] m_in;

    assign ctrl.shift  = push_i;
    assign ctrl.merge  = (i == 0) ? merge_i : 1'b0;
    assign ctrl.active = (count_q > CNT_W'(i));

    if (i == 0) begin : g_head
      assign d_in = data_i;
      assign m_in = ALL_ONES;
    end else begin : g_body
      assign d_in = vals[i-1];
      assign m_in = mins[i-1];
    end

    ldbe_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .d_i    (d_in),
      .min_i  (m_in),
      .val_o  (vals[i]),
      .min_o  (mins[i])
    );
  end

  assign min_o   = mins[DEPTH-1];
  assign empty_o = (count_q == '0);

endmodule

/* rtl/ldbe_gain.sv */
// Gain divisor ceil(2*target/base), capped at 16, found by repeated addition.
module ldbe_gain (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] base_i,
  input  logic [15:0] target_i,
  output logic        done_o,
  output logic [4:0]  div_o
);
  import ldbe_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  k_q, k_d;
  logic [32:0] acc_q, acc_d;
  logic [31:0] base_q, base_d;
  logic [16:0] num_q, num_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    acc_d  = acc_q;
    base_d = base_q;
    num_d  = num_q;
    if (start_i) begin
      base_d = base_i;
      num_d  = {target_i, 1'b0};
      k_d    = 5'd1;
      acc_d  = {1'b0, base_i};
      if ((base_i == '0) || (base_i == ALL_ONES) || (target_i == '0)) begin
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      // The first multiple of base that reaches the numerator gives the ceiling.
      if ((acc_q >= 33'(num_q)) || (k_q == GAIN_CAP)) begin
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        acc_d = acc_q + 33'(base_q);
        k_d   = k_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    num_q  <= num_d;
  end

  assign done_o = done_q;
  assign div_o  = k_q;

endmodule

/* rtl/ledbat_delay_estimator_top.sv */
// Top level of the LEDBAT delay estimator: windows, sequencer, gain unit and ports.
//
//  Channel   Signals                                   Direction  Payload
//  in        in_valid_i / in_ready_o / in_data_i       to block   in_item_t
//  out       out_valid_o / out_ready_i / out_data_o    from block out_item_t
//  cfg       cfg_valid_i / cfg_ready_o / cfg_index_i   to block   cfg_data_i
//
// One input beat passes from one accepting edge to the next through the idle state,
// the update state, the scan state (it runs until the minimum has rippled through
// the larger window depth, one registered cell per cycle), the state that starts
// the gain unit, the wait state and the output state. The gain unit finishes early
// when the divisor is fixed at one, and otherwise when the repeated addition stops
// at multiple K (1 to 16).
// The block works on one beat at a time; in_ready_o is high in the idle state
// even while a finished result waits on the output register.
// Reset is asynchronous and active low; it clears the counts, the rollover
// time, the valid flag and the registers to their default values.
// A stall on the output holds the result in the output register; the next beat
// still runs and then waits in the output state, which keeps in_ready_o low.
// The configuration port never stalls.
module ledbat_delay_estimator_top #(
  parameter int unsigned NOISE_DEPTH = ldbe_pkg::DEF_NOISE_DEPTH,
  parameter int unsigned BASE_DEPTH  = ldbe_pkg::DEF_BASE_DEPTH,
  parameter int unsigned ROLLOVER_MS = ldbe_pkg::DEF_ROLLOVER_MS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ldbe_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ldbe_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ldbe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [15:0]                        cfg_data_i
);
  import ldbe_pkg::*;

  // The scan must cover the deeper of the two windows.
  localparam int unsigned SCAN_LEN = (NOISE_DEPTH > BASE_DEPTH) ? NOISE_DEPTH : BASE_DEPTH;
  localparam int unsigned SCAN_W   = $clog2(SCAN_LEN + 1);

  state_e state_q, state_d;

  logic [15:0] target_q;
  logic [4:0]  base_len_q;
  logic [4:0]  noise_len_q;

  in_item_t    item_q, item_d;
  out_item_t   res_q, res_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        valid_flag_q, valid_flag_d;
  logic [31:0] last_roll_q, last_roll_d;
  logic [SCAN_W-1:0] scan_q, scan_d;

  logic        sample_ok;
  logic        noise_push;
  logic        base_push;
  logic        base_merge;
  logic [31:0] noise_min;
  logic [31:0] base_min;
  logic        noise_empty;
  logic        base_empty;
  logic        gain_start;
  logic        gain_done;
  logic [4:0]  gain_div;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= RST_TARGET_MS;
      base_len_q  <= RST_BASE_LEN;
      noise_len_q <= RST_NOISE_LEN;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TARGET_MS: target_q    <= cfg_data_i;
        CFG_BASE_LEN:  base_len_q  <= cfg_data_i[4:0];
        CFG_NOISE_LEN: noise_len_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Window updates happen only in the update state.
  assign sample_ok  = item_q.rtt_positive && item_q.timestamp_ok;
  assign noise_push = (state_q == ST_UPDATE) && sample_ok;

  always_comb begin
    base_push   = 1'b0;
    base_merge  = 1'b0;
    last_roll_d = last_roll_q;
    if ((state_q == ST_UPDATE) && sample_ok) begin
      if (base_empty) begin
        // The first bucket opens without moving the rollover time.
        base_push = 1'b1;
      end else if ((item_q.now_ms - last_roll_q) > 32'(ROLLOVER_MS)) begin
        base_push   = 1'b1;
        last_roll_d = item_q.now_ms;
      end else begin
        base_merge = 1'b1;
      end
    end
  end

  ldbe_window #(
    .DEPTH (NOISE_DEPTH)
  ) u_noise (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (noise_push),
    .merge_i (1'b0),
    .data_i  (item_q.rtt_ms),
    .len_i   (noise_len_q),
    .min_o   (noise_min),
    .empty_o (noise_empty)
  );

  ldbe_window #(
    .DEPTH (BASE_DEPTH)
  ) u_base (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (base_push),
    .merge_i (base_merge),
    .data_i  (item_q.rtt_ms),
    .len_i   (base_len_q),
    .min_o   (base_min),
    .empty_o (base_empty)
  );

  assign gain_start = (state_q == ST_GAIN);

  ldbe_gain u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (gain_start),
    .base_i   (res_q.base_ms),
    .target_i (target_q),
    .done_o   (gain_done),
    .div_o    (gain_div)
  );

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    valid_flag_d = valid_flag_q;
    scan_d       = scan_q;
    in_ready_o   = (state_q == ST_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        valid_flag_d = sample_ok;
        scan_d       = '0;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        scan_d = scan_q + SCAN_W'(1);
        // The last cell sees the newest sample once the scan reaches the depth.
        if (scan_q == SCAN_W'(SCAN_LEN)) begin
          state_d = ST_GAIN;
          // The minimum chains have settled; latch the delays for the gain unit.
          res_d.current_delay = noise_empty ? ALL_ONES : noise_min;
          res_d.base_ms       = base_empty ? ALL_ONES : base_min;
          res_d.delay_valid   = valid_flag_q;
        end
      end
      ST_GAIN: begin
        res_d.queue_ms = (res_q.current_delay > res_q.base_ms)
                       ? res_q.current_delay - res_q.base_ms : '0;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (gain_done) begin
          res_d.gain_divisor = gain_div;
          state_d            = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      valid_flag_q <= 1'b0;
      last_roll_q  <= '0;
      scan_q       <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      valid_flag_q <= valid_flag_d;
      last_roll_q  <= last_roll_d;
      scan_q       <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // An accepted beat keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.gain_divisor >= 5'd1) && (out_data_o.gain_divisor <= GAIN_CAP))
    else $error("gain divisor out of range");

  a_div_empty_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.base_ms == ALL_ONES) |-> (out_data_o.gain_divisor == 5'd1))
    else $error("empty base history must give divisor one");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.queue_ms <= out_data_o.current_delay))
    else $error("queue delay above current delay");
`endif

endmodule

/* tb/ledbat_delay_estimator_top_tb.sv */
// Self-checking testbench for the LEDBAT delay estimator with its own delay and gain predictor.
module ledbat_delay_estimator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ldbe_pkg::*;

  // Run shape: phases, beats per phase, sink hold-off, drain and watchdog limit.
  localparam int unsigned PHASES          = 14;
  localparam int unsigned ITEMS_PER_PHASE = 102;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;

  localparam int unsigned NOISE_SLOTS = DEF_NOISE_DEPTH;
  localparam int unsigned BASE_SLOTS  = DEF_BASE_DEPTH;
  localparam logic [31:0] ROLLOVER    = 32'(DEF_ROLLOVER_MS);

  // The register index that has no register behind it; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Result of any item while both windows are still empty.
  localparam out_item_t EMPTY_EST = '{ALL_ONES, ALL_ONES, 32'd0, 1'b0, 5'd1};
  // Result after the first valid sample of 100 ms with the 60 ms default target.
  localparam out_item_t FIRST_EST = '{32'd100, 32'd100, 32'd0, 1'b1, 5'd2};
  localparam out_item_t NO_PIN    = '0;

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t want;
  } dir_row_t;

  // Directed rows, run with the reset register values. Only the rows whose
  // result is obvious carry it; the rest go through the predictor.
  dir_row_t directed_rows [20] = '{
    // Invalid beats on an empty block, with rtt and time at their extremes.
    '{'{32'd0,         1'b0, 1'b1, 32'd0},         1'b1, EMPTY_EST},
    '{'{32'hFFFF_FFFE, 1'b1, 1'b0, 32'hFFFF_FFFF}, 1'b1, EMPTY_EST},
    '{'{32'hFFFF_FFFE, 1'b0, 1'b0, 32'h1234_5678}, 1'b1, EMPTY_EST},
    // First sample opens the first bucket without moving the rollover time.
    '{'{32'd100,       1'b1, 1'b1, 32'd1000},      1'b1, FIRST_EST},
    '{'{32'd150,       1'b1, 1'b1, 32'd2000},      1'b1, FIRST_EST},
    // More than a minute after time zero: second bucket.
    '{'{32'd50,        1'b1, 1'b1, 32'd61001},     1'b0, NO_PIN},
    // Tiny base drives the gain divisor into its cap, then a zero base.
    '{'{32'd1,         1'b1, 1'b1, 32'd61002},     1'b0, NO_PIN},
    '{'{32'd0,         1'b1, 1'b1, 32'd61003},     1'b0, NO_PIN},
    '{'{32'd200,       1'b1, 1'b0, 32'd61004},     1'b0, NO_PIN},
    // Push the small samples out of the four-deep noise window.
    '{'{32'd300,       1'b1, 1'b1, 32'd61005},     1'b0, NO_PIN},
    '{'{32'd400,       1'b1, 1'b1, 32'd61006},     1'b0, NO_PIN},
    '{'{32'd500,       1'b1, 1'b1, 32'd61007},     1'b0, NO_PIN},
    '{'{32'd600,       1'b1, 1'b1, 32'd61008},     1'b0, NO_PIN},
    // Rollover, then exactly one minute (stays), then one minute plus 1 ms.
    '{'{32'd70,        1'b1, 1'b1, 32'd121003},    1'b0, NO_PIN},
    '{'{32'd80,        1'b1, 1'b1, 32'd181003},    1'b0, NO_PIN},
    '{'{32'd90,        1'b1, 1'b1, 32'd181004},    1'b0, NO_PIN},
    // Time wraps around zero and back.
    '{'{32'hFFFF_FFFE, 1'b1, 1'b1, 32'd0},         1'b0, NO_PIN},
    '{'{32'h8000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b0, NO_PIN},
    '{'{32'h7FFF_FFFF, 1'b1, 1'b1, 32'd0},         1'b0, NO_PIN},
    '{'{32'h5555_5555, 1'b0, 1'b1, 32'hAAAA_AAAA}, 1'b0, NO_PIN}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  ledbat_delay_estimator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  // Mirror of the block's state and registers, owned by the predictor.
  logic [15:0] target_m     = RST_TARGET_MS;
  logic [4:0]  base_len_m   = RST_BASE_LEN;
  logic [4:0]  noise_len_m  = RST_NOISE_LEN;
  logic [31:0] noise_hist[$];
  logic [31:0] minute_mins[$];
  logic [31:0] last_rollover = '0;
  logic        delay_flag    = 1'b0;

  // Expected estimates, oldest first, one per accepted input beat.
  out_item_t pending_estimates[$];
  out_item_t oldest_est;

  // Stimulus controls shared between the sequencer and the sink, and the sample clock.
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  logic [31:0] now_clock = '0;

  int unsigned n_errors    = 0;
  int unsigned n_items     = 0;
  int unsigned n_valid     = 0;
  int unsigned n_rollovers = 0;
  int unsigned n_results   = 0;
  int unsigned n_cfg       = 0;
  int unsigned n_holds     = 0;
  int unsigned quiet_cycles = 0;

  // A length register of zero acts as one, and anything past the depth as the depth.
  function automatic int unsigned span(input logic [4:0] raw, input int unsigned depth);
    if (raw == 5'd0) return 1;
    if (raw > depth) return depth;
    return 32'(raw);
  endfunction

  // Append the newest entry, then drop the oldest ones down to the window length.
  // A window that was shortened keeps its surplus until this is called.
  function automatic void keep_newest(ref logic [31:0] win[$], input int unsigned lim,
                                      input logic [31:0] v);
    win = {win, v};
    while (win.size() > lim) void'(win.pop_front());
  endfunction

  function automatic logic [31:0] window_low(input logic [31:0] win[$]);
    logic [31:0] m;
    m = ALL_ONES;
    foreach (win[i]) if (win[i] < m) m = win[i];
    return m;
  endfunction

  // Advances the mirrored state by one acknowledgement and returns what the block
  // should report for it.
  function automatic out_item_t estimate_delays(input in_item_t it);
    out_item_t        est;
    logic [31:0]      elapsed;
    longint unsigned  ratio;
    if (it.rtt_positive && it.timestamp_ok) begin
      delay_flag = 1'b1;
      n_valid++;
      keep_newest(noise_hist, span(noise_len_m, NOISE_SLOTS), it.rtt_ms);
      elapsed = it.now_ms - last_rollover;
      if (minute_mins.size() == 0) begin
        keep_newest(minute_mins, span(base_len_m, BASE_SLOTS), it.rtt_ms);
      end else if (elapsed > ROLLOVER) begin
        last_rollover = it.now_ms;
        n_rollovers++;
        keep_newest(minute_mins, span(base_len_m, BASE_SLOTS), it.rtt_ms);
      end else if (it.rtt_ms < minute_mins[minute_mins.size()-1]) begin
        minute_mins[minute_mins.size()-1] = it.rtt_ms;
      end
    end else begin
      delay_flag = 1'b0;
    end
    est.current_delay = window_low(noise_hist);
    est.base_ms       = window_low(minute_mins);
    est.queue_ms      = (est.current_delay > est.base_ms) ?
                        est.current_delay - est.base_ms : 32'd0;
    est.delay_valid   = delay_flag;
    if (est.base_ms == 32'd0 || est.base_ms == ALL_ONES || target_m == 16'd0) begin
      est.gain_divisor = 5'd1;
    end else begin
      // Exact ceiling of 2*target/base, capped.
      ratio = (2 * longint'(target_m) + longint'(est.base_ms) - 1) /
              longint'(est.base_ms);
      est.gain_divisor = (ratio > GAIN_CAP) ? GAIN_CAP : 5'(ratio);
    end
    return est;
  endfunction

  // Offers one beat, sometimes after a random gap, and records its estimate once
  // the block takes it. Without a gap, valid stays high from one beat straight into the next.
  task automatic offer_item(input in_item_t it, input bit pinned, input out_item_t pin);
    out_item_t want;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    want = estimate_delays(it);
    if (pinned) want = pin;
    pending_estimates = {pending_estimates, want};
    n_items++;
  endtask

  // One register write; the caller lowers the valid after its last write so
  // back-to-back writes never lower and raise it in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TARGET_MS: target_m    = data;
      CFG_BASE_LEN:  base_len_m  = data[4:0];
      CFG_NOISE_LEN: noise_len_m = data[4:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  // Random acknowledgement around a path delay. Time mostly creeps forward, with
  // a fair share of steps that land right at or past the one-minute boundary.
  function automatic in_item_t make_sample(input logic [31:0] path);
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      0, 1:    now_clock = $urandom;
      2, 3, 4: now_clock = now_clock + $urandom_range(60001, 400000);
      5, 6:    now_clock = now_clock + $urandom_range(59995, 60005);
      default: now_clock = now_clock + $urandom_range(0, 3000);
    endcase
    it.now_ms = now_clock;
    if (pick < 82) begin
      it.rtt_positive = 1'b1;
      it.timestamp_ok = 1'b1;
      if (pick < 6)       it.rtt_ms = $urandom;
      else if (pick < 8)  it.rtt_ms = 32'd0;
      else                it.rtt_ms = path + $urandom_range(0, path / 2 + 8);
    end else begin
      // Broken acknowledgement: at least one of the two checks fails.
      {it.rtt_positive, it.timestamp_ok} = 2'($urandom_range(0, 2));
      it.rtt_ms = $urandom;
    end
    if (it.rtt_ms == ALL_ONES) it.rtt_ms = ALL_ONES - 32'd1;
    return it;
  endfunction

  // Compare of one field of a result beat.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Result checker. Handshake signals and data are sampled at the edge as they
  // stood before it, so the order of processes within the step does not matter.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_estimates.size() == 0) begin
        $display("%0t ns: result beat with no estimate pending, got %0h", $time, out_data);
        n_errors++;
      end else begin
        oldest_est = pending_estimates.pop_front();
        check_field("current_delay", oldest_est.current_delay, out_data.current_delay);
        check_field("base_ms",       oldest_est.base_ms,       out_data.base_ms);
        check_field("queue_ms",      oldest_est.queue_ms,      out_data.queue_ms);
        check_field("delay_valid",   32'(oldest_est.delay_valid), 32'(out_data.delay_valid));
        check_field("gain_divisor",  32'(oldest_est.gain_divisor),
                    32'(out_data.gain_divisor));
      end
    end
  end

  // Result sink. It stalls in short random bursts while idling is on, and on
  // request it holds off for a long stretch so the block fills and stalls its
  // input while the sequencer keeps offering beats.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        n_holds++;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles, %0d estimates pending", $time,
                 quiet_cycles, pending_estimates.size());
        $display("ledbat_delay_estimator_top_tb: FAIL");
        $finish;
      end
    end
  end

  // Sequencer: reset, the directed rows on the reset register values, then
  // phases of random samples, each starting from an idle block with fresh register values.
  initial begin
    logic [15:0] tgt_data;
    logic [15:0] base_data;
    logic [15:0] noise_data;
    logic [31:0] path;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);
    in_valid <= 1'b0;

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      // Registers only change once every estimate has come back and the block is idle.
      while (pending_estimates.size() != 0) @(posedge clk);

      // The first phases walk the register extremes, including lengths of zero
      // and past the depth, a zero target and a window that gets shortened.
      case (ph)
        0: begin tgt_data = 16'd0;    base_data = 16'hFFE0; noise_data = 16'h001F; end
        1: begin tgt_data = 16'hFFFF; base_data = 16'h0010; noise_data = 16'h0001; end
        2: begin tgt_data = 16'd1;    base_data = 16'h0011; noise_data = 16'h0000; end
        3: begin tgt_data = 16'd200;  base_data = 16'h0002; noise_data = 16'h0010; end
        default: begin
          tgt_data   = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                       16'($urandom_range(1, 400));
          base_data  = {11'($urandom), 5'($urandom_range(0, 31))};
          noise_data = {11'($urandom), 5'($urandom_range(0, 31))};
        end
      endcase
      write_reg(CFG_TARGET_MS, tgt_data);
      write_reg(CFG_BASE_LEN, base_data);
      write_reg(CFG_NOISE_LEN, noise_data);
      if (ph == 0 || $urandom_range(0, 3) == 0)
        write_reg(CFG_UNUSED_IDX, 16'($urandom) | 16'h8001);
      cfg_valid <= 1'b0;

      // Keep the path delay on the scale of the target so the divisor spreads.
      path = (target_m == 16'd0) ? 32'($urandom_range(0, 1000)) :
             32'($urandom_range(1, 2 * target_m + 2));

      idle_on = (ph + 3 < PHASES) && (ph % 4 != 3);
      if (ph == 4 || ph == 8) hold_req = 1'b1;

      repeat (ITEMS_PER_PHASE) offer_item(make_sample(path), 1'b0, NO_PIN);
      in_valid <= 1'b0;
    end

    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_estimates.size() != 0) begin
      $display("%0t ns: %0d estimates never came back", $time, pending_estimates.size());
      n_errors += pending_estimates.size();
    end

    $display("Run covered %0d ack beats, %0d valid samples, %0d rollovers, %0d register writes.",
             n_items, n_valid, n_rollovers, n_cfg);
    $display("%0d long sink hold-offs; %0d result beats checked, %0d mismatches.",
             n_holds, n_results, n_errors);
    if (n_errors == 0) begin
      $display("ledbat_delay_estimator_top_tb: PASS");
    end else begin
      $display("ledbat_delay_estimator_top_tb: FAIL");
    end
    $finish;
  end

endmodule

/* ledbat_delay_estimator_top.f */
rtl/ldbe_pkg.sv
rtl/ldbe_cell.sv
rtl/ldbe_window.sv
rtl/ldbe_gain.sv
rtl/ledbat_delay_estimator_top.sv
tb/ledbat_delay_estimator_top_tb.sv
